FILE: src/tmi_pkg.sv
package tmi_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_EXEC    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // Instruction symbols of the tape language.
  localparam logic [7:0] OP_PLUS  = 8'h2B;
  localparam logic [7:0] OP_MINUS = 8'h2D;
  localparam logic [7:0] OP_RIGHT = 8'h3E;
  localparam logic [7:0] OP_LEFT  = 8'h3C;
  localparam logic [7:0] OP_DOT   = 8'h2E;
  localparam logic [7:0] OP_COMMA = 8'h2C;
  localparam logic [7:0] OP_OPEN  = 8'h5B;
  localparam logic [7:0] OP_CLOSE = 8'h5D;

  // Fixed-width part of one result item.
  typedef struct packed {
    logic       dot_valid;
    logic [7:0] dot_byte;
    logic       input_used;
    logic       halted;
    logic       store_full;
  } res_t;

endpackage

FILE: src/tape_machine_interpreter.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_kind, in_data_byte
// out      out_valid / out_ready  out_out_valid, out_out_byte, out_input_used,
//                                 out_halted, out_store_full,
//                                 out_cell_pointer, out_program_counter
//
// Append, restart and clear items, and an execute item on a halted program,
// go from idle straight to the result state; any other execute item passes
// through the execute state first. A bracket scan reads the program store one
// byte at a time, as the store has a single read port.
// Reset is immediate: a fill count marks the written part of the tape, so
// restart clears the tape without a clearing pass.
// One item is in work at a time; the output register lets the next item be
// accepted while a result waits for out_ready.
module tape_machine_interpreter #(
  parameter int TAPE_DEPTH = 32768,
  parameter int PROG_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_kind,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_out_valid,
  output logic [7:0]                       out_out_byte,
  output logic                             out_input_used,
  output logic                             out_halted,
  output logic                             out_store_full,
  output logic [$clog2(TAPE_DEPTH)-1:0]    out_cell_pointer,
  output logic [$clog2(PROG_DEPTH+1)-1:0]  out_program_counter
);

  import tmi_pkg::*;

  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int PW = $clog2(PROG_DEPTH + 1);

  logic [TW-1:0] tape_ptr;
  logic          tape_wr_en;
  logic [7:0]    tape_wr_data;
  logic          tape_clear;
  logic [7:0]    tape_cell;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic [TW-1:0] res_ptr;
  logic [PW-1:0] res_pc;

  // Sequencer with the program store.
  tmi_seq #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .PROG_DEPTH (PROG_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .tape_ptr     (tape_ptr),
    .tape_wr_en   (tape_wr_en),
    .tape_wr_data (tape_wr_data),
    .tape_clear   (tape_clear),
    .tape_cell    (tape_cell),
    .res_valid    (res_valid),
    .res          (res),
    .res_ptr      (res_ptr),
    .res_pc       (res_pc),
    .res_ready    (res_ready)
  );

  // Tape memory with its fill count.
  tmi_tape #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk       (clk),
    .rst_n     (rst_n),
    .ptr       (tape_ptr),
    .wr_en     (tape_wr_en),
    .wr_data   (tape_wr_data),
    .clear     (tape_clear),
    .cell_data (tape_cell)
  );

  // Result register toward the output channel.
  tmi_out #(
    .TW (TW),
    .PW (PW)
  ) u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_valid           (res_valid),
    .res                 (res),
    .res_ptr             (res_ptr),
    .res_pc              (res_pc),
    .res_ready           (res_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_valid       (out_out_valid),
    .out_out_byte        (out_out_byte),
    .out_input_used      (out_input_used),
    .out_halted          (out_halted),
    .out_store_full      (out_store_full),
    .out_cell_pointer    (out_cell_pointer),
    .out_program_counter (out_program_counter)
  );

endmodule

FILE: src/tmi_tape.sv
module tmi_tape #(
  parameter int TAPE_DEPTH = 32768
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(TAPE_DEPTH)-1:0] ptr,
  input  logic                          wr_en,
  input  logic [7:0]                    wr_data,
  input  logic                          clear,
  output logic [7:0]                    cell_data
);

  localparam int FW = $clog2(TAPE_DEPTH + 1);

  logic [7:0]    mem [TAPE_DEPTH];
  logic [7:0]    rdata_r;
  logic          hit_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [FW-1:0] ptr_ext;

  assign ptr_ext = FW'(ptr);

  // Tape memory: write at the pointer, registered read at the pointer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr] <= wr_data;
    end
    rdata_r <= mem[ptr];
    hit_r   <= (ptr_ext < fill_r);
  end

  // Cells at or above the fill count have not been written since the last
  // restart and read as zero. The pointer never runs ahead of the fill count.
  always_comb begin
    fill_nxt = fill_r;
    if (clear) begin
      fill_nxt = '0;
    end else if (wr_en && (ptr_ext == fill_r)) begin
      fill_nxt = fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign cell_data = hit_r ? rdata_r : 8'd0;

`ifndef SYNTH
  // A write never leaves an uninitialized cell below the fill count.
  a_write_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (ptr_ext <= fill_r))
    else $error("tape write beyond fill count");
`endif

endmodule

FILE: src/tmi_seq.sv
module tmi_seq #(
  parameter int TAPE_DEPTH = 32768,
  parameter int PROG_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_kind,
  input  logic [7:0]                       in_data_byte,
  output logic [$clog2(TAPE_DEPTH)-1:0]    tape_ptr,
  output logic                             tape_wr_en,
  output logic [7:0]                       tape_wr_data,
  output logic                             tape_clear,
  input  logic [7:0]                       tape_cell,
  output logic                             res_valid,
  output tmi_pkg::res_t                    res,
  output logic [$clog2(TAPE_DEPTH)-1:0]    res_ptr,
  output logic [$clog2(PROG_DEPTH+1)-1:0]  res_pc,
  input  logic                             res_ready
);

  import tmi_pkg::*;

  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int AW = $clog2(PROG_DEPTH);
  localparam int PW = $clog2(PROG_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_SCANF = 5'b00100,
    ST_SCANB = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic [TW-1:0] ptr_r, ptr_nxt;
  logic [PW-1:0] depth_r, depth_nxt;
  logic [7:0]    byte_r, byte_nxt;
  res_t          flags_r, flags_nxt;

  logic [7:0]    prog_mem [PROG_DEPTH];
  logic [7:0]    prog_rdata_r;
  logic          prog_we;
  logic [AW-1:0] prog_raddr;

  logic [7:0]    op;
  logic [PW-1:0] pc_inc;
  logic [PW-1:0] pc_dec;
  logic [PW-1:0] depth_step;

  assign op     = prog_rdata_r;
  assign pc_inc = pc_r + PW'(1);
  assign pc_dec = pc_r - PW'(1);

  // Program store: appends write at the length, reads follow the counter.
  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[len_r[AW-1:0]] <= in_data_byte;
    end
    prog_rdata_r <= prog_mem[prog_raddr];
  end

  // Bracket depth after the byte just read during a scan.
  always_comb begin
    depth_step = depth_r;
    if (state_r == ST_SCANF) begin
      if (op == OP_OPEN) begin
        depth_step = depth_r + PW'(1);
      end else if (op == OP_CLOSE) begin
        depth_step = depth_r - PW'(1);
      end
    end else begin
      if (op == OP_CLOSE) begin
        depth_step = depth_r + PW'(1);
      end else if (op == OP_OPEN) begin
        depth_step = depth_r - PW'(1);
      end
    end
  end

  // Sequencer: accept, fetch, execute, scan, then hand over the result.
  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    len_nxt      = len_r;
    ptr_nxt      = ptr_r;
    depth_nxt    = depth_r;
    byte_nxt     = byte_r;
    flags_nxt    = flags_r;
    prog_we      = 1'b0;
    prog_raddr   = pc_r[AW-1:0];
    tape_wr_en   = 1'b0;
    tape_wr_data = tape_cell;
    tape_clear   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_data_byte;
          flags_nxt = '0;
          state_nxt = ST_RESP;
          unique case (kind_t'(in_kind))
            KIND_APPEND: begin
              if (len_r != PW'(PROG_DEPTH)) begin
                prog_we = 1'b1;
                len_nxt = len_r + PW'(1);
              end else begin
                flags_nxt.store_full = 1'b1;
              end
            end
            KIND_EXEC: begin
              if (pc_r < len_r) begin
                state_nxt = ST_EXEC;
              end
            end
            KIND_RESTART: begin
              ptr_nxt    = '0;
              pc_nxt     = '0;
              tape_clear = 1'b1;
            end
            KIND_CLEAR: begin
              len_nxt = '0;
              pc_nxt  = '0;
            end
          endcase
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
        pc_nxt    = pc_inc;
        unique case (op)
          OP_PLUS: begin
            tape_wr_en   = 1'b1;
            tape_wr_data = tape_cell + 8'd1;
          end
          OP_MINUS: begin
            tape_wr_en   = 1'b1;
            tape_wr_data = tape_cell - 8'd1;
          end
          OP_RIGHT: begin
            // Writing the cell back keeps the fill count up with the pointer.
            if (ptr_r != TW'(TAPE_DEPTH - 1)) begin
              tape_wr_en = 1'b1;
              ptr_nxt    = ptr_r + TW'(1);
            end
          end
          OP_LEFT: begin
            if (ptr_r != '0) begin
              ptr_nxt = ptr_r - TW'(1);
            end
          end
          OP_DOT: begin
            flags_nxt.dot_valid = 1'b1;
            flags_nxt.dot_byte  = tape_cell;
          end
          OP_COMMA: begin
            tape_wr_en            = 1'b1;
            tape_wr_data          = byte_r;
            flags_nxt.input_used  = 1'b1;
          end
          OP_OPEN: begin
            if (tape_cell == 8'd0) begin
              depth_nxt  = PW'(1);
              prog_raddr = pc_inc[AW-1:0];
              if (pc_inc < len_r) begin
                state_nxt = ST_SCANF;
              end
            end
          end
          OP_CLOSE: begin
            if ((tape_cell != 8'd0) && (pc_r != '0)) begin
              depth_nxt  = PW'(1);
              pc_nxt     = pc_dec;
              prog_raddr = pc_dec[AW-1:0];
              state_nxt  = ST_SCANB;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCANF: begin
        // The counter holds the scan position; one byte is checked per cycle.
        pc_nxt     = pc_inc;
        prog_raddr = pc_inc[AW-1:0];
        if ((depth_step == '0) || (pc_inc >= len_r)) begin
          state_nxt = ST_RESP;
        end else begin
          depth_nxt = depth_step;
        end
      end
      ST_SCANB: begin
        if ((depth_step == '0) || (pc_r == '0)) begin
          pc_nxt    = pc_inc;
          state_nxt = ST_RESP;
        end else begin
          pc_nxt     = pc_dec;
          prog_raddr = pc_dec[AW-1:0];
          depth_nxt  = depth_step;
        end
      end
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      len_r   <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      len_r   <= len_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // Working values of the current item.
  always_ff @(posedge clk) begin
    depth_r <= depth_nxt;
    byte_r  <= byte_nxt;
    flags_r <= flags_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign tape_ptr  = ptr_r;
  assign res_ptr   = ptr_r;
  assign res_pc    = pc_r;

  always_comb begin
    res        = flags_r;
    res.halted = (pc_r >= len_r);
  end

`ifndef SYNTH
  // Execution and scans only ever look inside the stored program.
  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) || (state_r == ST_SCANF) || (state_r == ST_SCANB))
      |-> (pc_r < len_r))
    else $error("program counter outside program during execution");

  // The program length never exceeds the store.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= PW'(PROG_DEPTH))
    else $error("program length beyond store depth");

  // The tape is written only while an instruction executes.
  a_tape_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    tape_wr_en |-> (state_r == ST_EXEC))
    else $error("tape write outside execute state");
`endif

endmodule

FILE: src/tmi_out.sv
module tmi_out #(
  parameter int TW = 15,
  parameter int PW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  tmi_pkg::res_t res,
  input  logic [TW-1:0] res_ptr,
  input  logic [PW-1:0] res_pc,
  output logic          res_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_out_valid,
  output logic [7:0]    out_out_byte,
  output logic          out_input_used,
  output logic          out_halted,
  output logic          out_store_full,
  output logic [TW-1:0] out_cell_pointer,
  output logic [PW-1:0] out_program_counter
);

  import tmi_pkg::*;

  logic          valid_r, valid_nxt;
  logic          load;
  res_t          res_r;
  logic [TW-1:0] ptr_r;
  logic [PW-1:0] pc_r;

  // Output register: takes a new item when empty or being drained.
  assign res_ready = !valid_r || out_ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
      ptr_r <= res_ptr;
      pc_r  <= res_pc;
    end
  end

  assign out_valid           = valid_r;
  assign out_out_valid       = res_r.dot_valid;
  assign out_out_byte        = res_r.dot_byte;
  assign out_input_used      = res_r.input_used;
  assign out_halted          = res_r.halted;
  assign out_store_full      = res_r.store_full;
  assign out_cell_pointer    = ptr_r;
  assign out_program_counter = pc_r;

endmodule
